/* design/pdll_pkg.sv */
`timescale 1ns / 1ps
package pdll_pkg;

    localparam int Capacity   = 256;
    localparam int PoolDepth  = Capacity + 1;
    localparam int SlotWidth  = 9;
    localparam int ValueWidth = 32;
    localparam int PosWidth   = 8;

    typedef logic [SlotWidth-1:0]  t_slot;
    typedef logic [ValueWidth-1:0] t_value;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_FIND   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_LISTED = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_BAD_SLOT  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_INS2,
        S_INS3,
        S_REM2,
        S_APP2,
        S_WALK,
        S_RESP
    } t_state;

    typedef struct packed {
        logic  we;
        t_slot addr;
        t_slot data;
    } t_link_wr;

    typedef struct packed {
        logic  we;
        t_slot addr;
        logic  data;
    } t_used_wr;

    typedef struct packed {
        logic   we;
        t_slot  addr;
        t_value data;
    } t_val_wr;

    typedef struct packed {
        t_slot next_ra;
        t_slot prev_ra;
        t_slot used_ra;
        t_slot val_ra;
    } t_rd_addr;

endpackage

/* design/pdll_mem.sv */
`timescale 1ns / 1ps
module pdll_mem (
    input  logic                i_clk,
    input  pdll_pkg::t_link_wr  i_next_wr,
    input  pdll_pkg::t_link_wr  i_prev_wr,
    input  pdll_pkg::t_used_wr  i_used_wr,
    input  pdll_pkg::t_val_wr   i_val_wr,
    input  pdll_pkg::t_rd_addr  i_rd,
    output pdll_pkg::t_slot     o_next_rd,
    output pdll_pkg::t_slot     o_prev_rd,
    output logic                o_used_rd,
    output pdll_pkg::t_value    o_val_rd
);

    pdll_pkg::t_slot  next_mem [0:pdll_pkg::PoolDepth-1];
    pdll_pkg::t_slot  prev_mem [0:pdll_pkg::PoolDepth-1];
    logic             used_mem [0:pdll_pkg::PoolDepth-1];
    pdll_pkg::t_value val_mem  [0:pdll_pkg::PoolDepth-1];

    pdll_pkg::t_slot  r_next_rd;
    pdll_pkg::t_slot  r_prev_rd;
    logic             r_used_rd;
    pdll_pkg::t_value r_val_rd;

    always_ff @(posedge i_clk) begin
        if (i_next_wr.we) next_mem[i_next_wr.addr] <= i_next_wr.data;
        if (i_prev_wr.we) prev_mem[i_prev_wr.addr] <= i_prev_wr.data;
        if (i_used_wr.we) used_mem[i_used_wr.addr] <= i_used_wr.data;
        if (i_val_wr.we)  val_mem[i_val_wr.addr]   <= i_val_wr.data;
        r_next_rd <= next_mem[i_rd.next_ra];
        r_prev_rd <= prev_mem[i_rd.prev_ra];
        r_used_rd <= used_mem[i_rd.used_ra];
        r_val_rd  <= val_mem[i_rd.val_ra];
    end

    assign o_next_rd = r_next_rd;
    assign o_prev_rd = r_prev_rd;
    assign o_used_rd = r_used_rd;
    assign o_val_rd  = r_val_rd;

endmodule

/* design/pooled_doubly_linked_list.sv */
`timescale 1ns / 1ps
// Doubly linked list over a fixed pool of 256 slots with a free chain.
// Request channel: i_valid / o_stall with i_cmd, i_slot, i_value, i_position.
// Result channel: o_valid / i_stall with o_status, o_result_slot,
// o_found_value, o_count, o_in_slot_order; one result per request.
// One request is processed at a time by a sequencer around the link, flag
// and value memories (registered reads).
// States after accept: insert READ, INS2, INS3; remove READ, REM2;
// append READ (and APP2 if not empty); find READ, WALK; errors READ.
// The link walk of find runs one next-link read per cycle.
// The result register frees the sequencer: the next request is accepted
// while a result is still stalled; a new result waits in its final state
// until the result register is free.
// After reset a clearing pass over all 257 pool entries builds the free
// chain and clears the slot flags; o_stall is high during that pass.
module pooled_doubly_linked_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [8:0]  i_slot,
    input  logic [31:0] i_value,
    input  logic [7:0]  i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [8:0]  o_result_slot,
    output logic [31:0] o_found_value,
    output logic [8:0]  o_count,
    output logic        o_in_slot_order
);

    pdll_pkg::t_state  r_state, n_state;
    pdll_pkg::t_slot   r_clr, n_clr;
    pdll_pkg::t_cmd    r_cmd, n_cmd;
    pdll_pkg::t_slot   r_slot, n_slot;
    pdll_pkg::t_value  r_value, n_value;
    logic [7:0]        r_pos, n_pos;
    logic [7:0]        r_idx, n_idx;
    pdll_pkg::t_slot   r_first, n_first;
    pdll_pkg::t_slot   r_last, n_last;
    pdll_pkg::t_slot   r_free, n_free;
    pdll_pkg::t_slot   r_count, n_count;
    logic              r_flag, n_flag;
    pdll_pkg::t_slot   r_cur, n_cur;
    pdll_pkg::t_slot   r_aux, n_aux;
    pdll_pkg::t_slot   r_aux2, n_aux2;
    pdll_pkg::t_status r_status, n_status;
    pdll_pkg::t_slot   r_rslot, n_rslot;
    pdll_pkg::t_value  r_fval, n_fval;
    logic              r_ovalid, n_ovalid;
    logic [2:0]        r_ostatus, n_ostatus;
    pdll_pkg::t_slot   r_orslot, n_orslot;
    pdll_pkg::t_value  r_ofval, n_ofval;
    pdll_pkg::t_slot   r_ocount, n_ocount;
    logic              r_oflag, n_oflag;

    pdll_pkg::t_link_wr next_wr, prev_wr;
    pdll_pkg::t_used_wr used_wr;
    pdll_pkg::t_val_wr  val_wr;
    pdll_pkg::t_rd_addr rd;
    pdll_pkg::t_slot    next_rd, prev_rd;
    logic               used_rd;
    pdll_pkg::t_value   val_rd;
    logic               bad_slot;

    pdll_mem u_mem (
        .i_clk     (i_clk),
        .i_next_wr (next_wr),
        .i_prev_wr (prev_wr),
        .i_used_wr (used_wr),
        .i_val_wr  (val_wr),
        .i_rd      (rd),
        .o_next_rd (next_rd),
        .o_prev_rd (prev_rd),
        .o_used_rd (used_rd),
        .o_val_rd  (val_rd)
    );

    assign bad_slot = (r_slot == '0) ||
                      (r_slot > pdll_pkg::SlotWidth'(pdll_pkg::Capacity));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pdll_pkg::S_CLEAR;
            r_clr    <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_free   <= pdll_pkg::SlotWidth'(1);
            r_count  <= '0;
            r_flag   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_first  <= n_first;
            r_last   <= n_last;
            r_free   <= n_free;
            r_count  <= n_count;
            r_flag   <= n_flag;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_slot    <= n_slot;
        r_value   <= n_value;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_cur     <= n_cur;
        r_aux     <= n_aux;
        r_aux2    <= n_aux2;
        r_status  <= n_status;
        r_rslot   <= n_rslot;
        r_fval    <= n_fval;
        r_ostatus <= n_ostatus;
        r_orslot  <= n_orslot;
        r_ofval   <= n_ofval;
        r_ocount  <= n_ocount;
        r_oflag   <= n_oflag;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_cmd     = r_cmd;
        n_slot    = r_slot;
        n_value   = r_value;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_first   = r_first;
        n_last    = r_last;
        n_free    = r_free;
        n_count   = r_count;
        n_flag    = r_flag;
        n_cur     = r_cur;
        n_aux     = r_aux;
        n_aux2    = r_aux2;
        n_status  = r_status;
        n_rslot   = r_rslot;
        n_fval    = r_fval;
        n_ovalid  = r_ovalid && i_stall;
        n_ostatus = r_ostatus;
        n_orslot  = r_orslot;
        n_ofval   = r_ofval;
        n_ocount  = r_ocount;
        n_oflag   = r_oflag;
        next_wr   = '0;
        prev_wr   = '0;
        used_wr   = '0;
        val_wr    = '0;
        rd        = '0;
        o_stall   = 1'b1;

        case (r_state)
            pdll_pkg::S_CLEAR: begin
                next_wr.we   = 1'b1;
                next_wr.addr = r_clr;
                next_wr.data = (r_clr != '0 &&
                                r_clr < pdll_pkg::SlotWidth'(pdll_pkg::Capacity)) ?
                               r_clr + 1'b1 : '0;
                prev_wr.we   = 1'b1;
                prev_wr.addr = r_clr;
                used_wr.we   = 1'b1;
                used_wr.addr = r_clr;
                n_clr        = r_clr + 1'b1;
                if (r_clr == pdll_pkg::SlotWidth'(pdll_pkg::Capacity)) begin
                    n_state = pdll_pkg::S_IDLE;
                end
            end
            pdll_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                rd.next_ra = (pdll_pkg::t_cmd'(i_cmd) == pdll_pkg::CMD_APPEND) ?
                             r_free : i_slot;
                rd.prev_ra = i_slot;
                rd.used_ra = i_slot;
                if (i_valid) begin
                    n_cmd    = pdll_pkg::t_cmd'(i_cmd);
                    n_slot   = i_slot;
                    n_value  = i_value;
                    n_pos    = i_position;
                    n_status = pdll_pkg::ST_OK;
                    n_rslot  = '0;
                    n_fval   = '0;
                    n_state  = pdll_pkg::S_READ;
                end
            end
            pdll_pkg::S_READ: begin
                n_state = pdll_pkg::S_RESP;
                case (r_cmd)
                    pdll_pkg::CMD_INSERT, pdll_pkg::CMD_REMOVE: begin
                        if (bad_slot) begin
                            n_status = pdll_pkg::ST_BAD_SLOT;
                        end else if (!used_rd) begin
                            n_status = pdll_pkg::ST_NOT_LISTED;
                        end else if (r_cmd == pdll_pkg::CMD_INSERT) begin
                            if (r_free == '0) begin
                                n_status = pdll_pkg::ST_FULL;
                            end else begin
                                n_cur        = r_free;
                                n_aux        = prev_rd;
                                rd.next_ra   = r_free;
                                prev_wr.we   = 1'b1;
                                prev_wr.addr = r_slot;
                                prev_wr.data = r_free;
                                used_wr.we   = 1'b1;
                                used_wr.addr = r_free;
                                used_wr.data = 1'b1;
                                val_wr.we    = 1'b1;
                                val_wr.addr  = r_free;
                                val_wr.data  = r_value;
                                n_state      = pdll_pkg::S_INS2;
                            end
                        end else begin
                            n_aux        = prev_rd;
                            n_aux2       = next_rd;
                            prev_wr.we   = 1'b1;
                            prev_wr.addr = r_slot;
                            used_wr.we   = 1'b1;
                            used_wr.addr = r_slot;
                            next_wr.we   = 1'b1;
                            next_wr.addr = r_slot;
                            next_wr.data = r_free;
                            n_free       = r_slot;
                            n_flag       = 1'b0;
                            n_count      = r_count - 1'b1;
                            n_rslot      = r_slot;
                            if (prev_rd == '0) n_first = next_rd;
                            if (next_rd == '0) n_last = prev_rd;
                            n_state      = pdll_pkg::S_REM2;
                        end
                    end
                    pdll_pkg::CMD_APPEND: begin
                        if (r_free == '0) begin
                            n_status = pdll_pkg::ST_FULL;
                        end else begin
                            n_free       = next_rd;
                            next_wr.we   = 1'b1;
                            next_wr.addr = r_free;
                            prev_wr.we   = 1'b1;
                            prev_wr.addr = r_free;
                            prev_wr.data = (r_count == '0) ? '0 : r_last;
                            used_wr.we   = 1'b1;
                            used_wr.addr = r_free;
                            used_wr.data = 1'b1;
                            val_wr.we    = 1'b1;
                            val_wr.addr  = r_free;
                            val_wr.data  = r_value;
                            n_count      = r_count + 1'b1;
                            n_rslot      = r_free;
                            n_cur        = r_free;
                            n_aux        = r_last;
                            n_last       = r_free;
                            if (r_count == '0) begin
                                n_first = r_free;
                            end else begin
                                if (r_free != r_last + 1'b1) n_flag = 1'b0;
                                n_state = pdll_pkg::S_APP2;
                            end
                        end
                    end
                    default: begin
                        if ({1'b0, r_pos} >= r_count) begin
                            n_status = pdll_pkg::ST_BAD_POS;
                        end else begin
                            n_cur      = r_first;
                            n_idx      = '0;
                            rd.next_ra = r_first;
                            rd.val_ra  = r_first;
                            n_state    = pdll_pkg::S_WALK;
                        end
                    end
                endcase
            end
            pdll_pkg::S_INS2: begin
                n_free       = next_rd;
                next_wr.we   = 1'b1;
                next_wr.addr = r_cur;
                next_wr.data = r_slot;
                prev_wr.we   = 1'b1;
                prev_wr.addr = r_cur;
                prev_wr.data = r_aux;
                n_state      = pdll_pkg::S_INS3;
            end
            pdll_pkg::S_INS3: begin
                if (r_aux == '0) begin
                    n_first = r_cur;
                end else begin
                    next_wr.we   = 1'b1;
                    next_wr.addr = r_aux;
                    next_wr.data = r_cur;
                end
                n_count = r_count + 1'b1;
                if (r_cur + 1'b1 != r_slot) n_flag = 1'b0;
                n_rslot = r_cur;
                n_state = pdll_pkg::S_RESP;
            end
            pdll_pkg::S_REM2: begin
                next_wr.we   = (r_aux != '0);
                next_wr.addr = r_aux;
                next_wr.data = r_aux2;
                prev_wr.we   = (r_aux2 != '0);
                prev_wr.addr = r_aux2;
                prev_wr.data = r_aux;
                n_state      = pdll_pkg::S_RESP;
            end
            pdll_pkg::S_APP2: begin
                next_wr.we   = 1'b1;
                next_wr.addr = r_aux;
                next_wr.data = r_cur;
                n_state      = pdll_pkg::S_RESP;
            end
            pdll_pkg::S_WALK: begin
                if (r_idx == r_pos) begin
                    n_rslot = r_cur;
                    n_fval  = val_rd;
                    n_state = pdll_pkg::S_RESP;
                end else begin
                    n_cur      = next_rd;
                    n_idx      = r_idx + 1'b1;
                    rd.next_ra = next_rd;
                    rd.val_ra  = next_rd;
                end
            end
            pdll_pkg::S_RESP: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_orslot  = r_rslot;
                    n_ofval   = r_fval;
                    n_ocount  = r_count;
                    n_oflag   = r_flag;
                    n_state   = pdll_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pdll_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_result_slot   = r_orslot;
    assign o_found_value   = r_ofval;
    assign o_count         = r_ocount;
    assign o_in_slot_order = r_oflag;

endmodule

/* sim/tb_pooled_doubly_linked_list.sv */
`timescale 1ns / 1ps
module tb_pooled_doubly_linked_list;

    typedef struct {
        logic [2:0]  status;
        logic [8:0]  rslot;
        logic [31:0] fval;
        logic [8:0]  count;
        logic        order;
    } t_list_result;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [1:0]  i_cmd = 0;
    logic [8:0]  i_slot = 0;
    logic [31:0] i_value = 0;
    logic [7:0]  i_position = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [8:0]  o_result_slot;
    logic [31:0] o_found_value;
    logic [8:0]  o_count;
    logic        o_in_slot_order;

    pooled_doubly_linked_list DUT (.*);

    always #5 i_clk = ~i_clk;

    // shadow list
    logic [8:0]  nxt [0:pdll_pkg::Capacity];
    logic [8:0]  prv [0:pdll_pkg::Capacity];
    logic        used [0:pdll_pkg::Capacity];
    logic [31:0] vals [0:pdll_pkg::Capacity];
    logic [8:0]  head, tail, free_head, n_elem;
    logic        in_order;

    t_list_result pending_results[$];
    int errors = 0, n_checked = 0, idle_cycles = 0;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit hold_recv = 0, timed_out = 0;
    int n_sent = 0;

    task automatic list_reset();
        for (int i = 0; i <= pdll_pkg::Capacity; i++) begin
            nxt[i] = (i >= 1 && i < pdll_pkg::Capacity) ? 9'(i + 1) : 9'd0;
            prv[i] = 0;
            used[i] = 0;
            vals[i] = 0;
        end
        head = 0; tail = 0; free_head = 1; n_elem = 0; in_order = 1;
    endtask

    function automatic t_list_result list_apply(pdll_pkg::t_cmd c, logic [8:0] s,
                                                logic [31:0] v, logic [7:0] p);
        t_list_result r;
        logic [8:0] cur, b, n;
        r.status = pdll_pkg::ST_OK; r.rslot = 0; r.fval = 0;
        if (c == pdll_pkg::CMD_INSERT || c == pdll_pkg::CMD_REMOVE) begin
            if (s == 0 || s > pdll_pkg::Capacity) r.status = pdll_pkg::ST_BAD_SLOT;
            else if (!used[s]) r.status = pdll_pkg::ST_NOT_LISTED;
            else if (c == pdll_pkg::CMD_INSERT) begin
                if (free_head == 0) r.status = pdll_pkg::ST_FULL;
                else begin
                    cur = free_head; free_head = nxt[cur];
                    b = prv[s];
                    nxt[cur] = s; prv[cur] = b;
                    if (b == 0) head = cur; else nxt[b] = cur;
                    prv[s] = cur; used[cur] = 1; vals[cur] = v;
                    n_elem++;
                    if (cur + 9'd1 != s) in_order = 0;
                    r.rslot = cur;
                end
            end else begin
                b = prv[s]; n = nxt[s];
                in_order = 0;
                if (b == 0) head = n; else nxt[b] = n;
                if (n == 0) tail = b; else prv[n] = b;
                prv[s] = 0; used[s] = 0;
                nxt[s] = free_head; free_head = s;
                n_elem--;
                r.rslot = s;
            end
        end else if (c == pdll_pkg::CMD_APPEND) begin
            if (free_head == 0) r.status = pdll_pkg::ST_FULL;
            else begin
                cur = free_head; free_head = nxt[cur];
                nxt[cur] = 0;
                if (n_elem == 0) begin
                    prv[cur] = 0; head = cur;
                end else begin
                    prv[cur] = tail; nxt[tail] = cur;
                    if (cur != tail + 9'd1) in_order = 0;
                end
                tail = cur; used[cur] = 1; vals[cur] = v;
                n_elem++;
                r.rslot = cur;
            end
        end else begin
            if (9'(p) >= n_elem) r.status = pdll_pkg::ST_BAD_POS;
            else begin
                cur = head;
                for (int i = 0; i < p; i++) cur = nxt[cur];
                r.rslot = cur; r.fval = vals[cur];
            end
        end
        r.count = n_elem; r.order = in_order;
        return r;
    endfunction

    task automatic send_request(pdll_pkg::t_cmd c, logic [8:0] s, logic [31:0] v,
                                logic [7:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_cmd <= c; i_slot <= s; i_value <= v; i_position <= p;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(list_apply(c, s, v, p));
        n_sent++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 0;
        else i_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_list_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result status=%0d", o_status);
            end else begin
                e = pending_results.pop_front();
                n_checked++;
                if (o_status !== e.status || o_result_slot !== e.rslot ||
                    o_found_value !== e.fval || o_count !== e.count ||
                    o_in_slot_order !== e.order) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp st=%0d sl=%0d v=%h n=%0d o=%0d ",
                                  "got st=%0d sl=%0d v=%h n=%0d o=%0d"},
                                 e.status, e.rslot, e.fval, e.count, e.order, o_status,
                                 o_result_slot, o_found_value, o_count, o_in_slot_order);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || hold_recv) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 5000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        i_valid <= 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [8:0] pick_listed();
        logic [8:0] s;
        for (int k = 0; k < 8; k++) begin
            s = 9'($urandom_range(1, pdll_pkg::Capacity));
            if (used[s]) return s;
        end
        return (head != 0) ? head : 9'($urandom_range(1, pdll_pkg::Capacity));
    endfunction

    task automatic test_directed();
        send_request(pdll_pkg::CMD_FIND, 0, 0, 0);
        send_request(pdll_pkg::CMD_REMOVE, 1, 0, 0);
        send_request(pdll_pkg::CMD_INSERT, 0, 32'hFFFF_FFFF, 0);
        send_request(pdll_pkg::CMD_REMOVE, 257, 0, 0);
        send_request(pdll_pkg::CMD_INSERT, 9'h1FF, 0, 0);
        send_request(pdll_pkg::CMD_APPEND, 9'h1FF, 32'hFFFF_FFFF, 8'hFF);
        send_request(pdll_pkg::CMD_APPEND, 0, 0, 0);
        send_request(pdll_pkg::CMD_APPEND, 0, 32'hA5A5_5A5A, 0);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'd2);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'd3);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'hFF);
        send_request(pdll_pkg::CMD_INSERT, 2, 32'h1234_5678, 0);
        send_request(pdll_pkg::CMD_INSERT, 1, 32'h8765_4321, 0);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'd1);
        send_request(pdll_pkg::CMD_REMOVE, 5, 0, 0);
        send_request(pdll_pkg::CMD_REMOVE, 256, 0, 0);
        send_request(pdll_pkg::CMD_REMOVE, 2, 0, 0);
        send_request(pdll_pkg::CMD_REMOVE, 1, 0, 0);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'd0);
        wait_drained();
    endtask

    task automatic test_fill_and_full();
        while (n_elem < pdll_pkg::Capacity)
            send_request(pdll_pkg::CMD_APPEND, 0, $urandom, 0);
        send_request(pdll_pkg::CMD_APPEND, 0, $urandom, 0);
        send_request(pdll_pkg::CMD_INSERT, pick_listed(), $urandom, 0);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'hFF);
        send_request(pdll_pkg::CMD_FIND, 0, 0, 8'($urandom));
        while (n_elem > 16) send_request(pdll_pkg::CMD_REMOVE, pick_listed(), 0, 0);
        wait_drained();
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 30)
                send_request(pdll_pkg::CMD_APPEND, 9'($urandom), $urandom, 8'($urandom));
            else if (r < 50)
                send_request(pdll_pkg::CMD_INSERT, pick_listed(), $urandom, 8'($urandom));
            else if (r < 72)
                send_request(pdll_pkg::CMD_REMOVE, pick_listed(), 0, 8'($urandom));
            else if (r < 92)
                send_request(pdll_pkg::CMD_FIND, 9'($urandom), $urandom,
                             8'($urandom_range(0, n_elem > 0 ? n_elem - 1 : 0)));
            else
                send_request(pdll_pkg::t_cmd'($urandom_range(3)), 9'($urandom), $urandom,
                             8'($urandom));
        end
    endtask

    task automatic test_backpressure();
        hold_recv = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_recv = 0;
            end
            for (int k = 0; k < 12; k++)
                send_request(pdll_pkg::CMD_FIND, 0, 0, 8'($urandom_range(0, 3)));
        join
        wait_drained();
    endtask

    initial begin
        list_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        send_idle_pct = 10; recv_idle_pct = 51;
        test_fill_and_full();
        test_random(370);
        wait_drained();
        test_backpressure();
        send_idle_pct = 51; recv_idle_pct = 10;
        test_random(370);
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(370);
        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d requests (%0d results): insert, append, remove, find,", n_sent,
                 n_checked);
        $display("full pool, bad slot, bad position, idle mixes and a long result stall.");
        if (errors == 0 && pending_results.size() == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule

/* files.f */
design/pdll_pkg.sv
design/pdll_mem.sv
design/pooled_doubly_linked_list.sv
sim/tb_pooled_doubly_linked_list.sv
